### design/imu_ja_pkg.sv
package imu_ja_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int QUAT_W          = 16;
  localparam int ANGLE_W         = 14;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 8;

  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 31;
  localparam int ACOS_STEPS = 32;
  localparam int LANES      = 6;
  // P1, P2, sqrt, multiply, prep, divide, three dot stages, acos, two final stages
  localparam int NUM_STAGES = 2 + SQ_STEPS + 2 + DIV_STEPS + 3 + ACOS_STEPS + 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ANGLE_METHOD = 8'd0,
    CFG_SUPPLEMENT   = 8'd1
  } cfg_reg_t;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam int THR_SH = 2 * QUAT_FRAC_BITS - 30;
  localparam logic [32:0] NEAR_ZERO_THR = (THR_SH >= 0) ? (33'd1 << THR_SH) : 33'd0;

  localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [23:0] SPAN_BONE = 24'(180 << ANGLE_FRAC_BITS);
  localparam logic [23:0] SPAN_DIFF = 24'(360 << ANGLE_FRAC_BITS);

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic [ANGLE_W-1:0]       angle_t;

  typedef struct packed {
    logic signed [31:0] ww;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] wz;
    logic signed [31:0] yz;
    logic signed [31:0] wx;
  } qprod_t;

  typedef struct packed {
    logic [32:0]       m_a;
    logic [32:0]       m_b;
    logic [2:0][32:0]  ca_mag;
    logic [2:0]        ca_neg;
    logic [2:0][32:0]  cb_mag;
    logic [2:0]        cb_neg;
    logic [32:0]       r_mag;
    logic              r_neg;
  } feat_t;

  typedef struct packed {
    logic [62:0] va;
    logic [62:0] ra;
    logic [62:0] vb;
    logic [62:0] rb;
  } sqrt_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [32:0] den;
    logic [30:0] quo;
    logic        neg;
  } lane_t;

  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    logic signed [33:0] n;
    n = -v;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

endpackage

### design/imu_joint_angle_from_quaternions.sv
// Joint angle from two segment orientation quaternions (Q14 in, degrees Q6 out).
// Input channel: in_valid/in_ready with eight quaternion fields, one word per
// pair of orientations. Output channel: out_valid/out_ready with joint_angle.
// Config channel: cfg_valid/cfg_ready, cfg_index selects angle_method (0) or
// anatomical_supplement (1); bit 0 of cfg_data is stored, other indexes are
// dropped. cfg_ready is always high; write only while the pipeline is empty.
// Throughput: one word per cycle unless the output stalls. Most of the pipeline
// is the 32-step square root, 31-step divider and 32-step arc cosine
// chains, each one step per stage.
// The whole pipeline advances as one: when out_valid is high and out_ready is
// low, every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset (synchronous, rst high) clears all valid bits and both config bits.
module imu_joint_angle_from_quaternions (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  imu_ja_pkg::quat_t                     quat_a_w,
  input  imu_ja_pkg::quat_t                     quat_a_x,
  input  imu_ja_pkg::quat_t                     quat_a_y,
  input  imu_ja_pkg::quat_t                     quat_a_z,
  input  imu_ja_pkg::quat_t                     quat_b_w,
  input  imu_ja_pkg::quat_t                     quat_b_x,
  input  imu_ja_pkg::quat_t                     quat_b_y,
  input  imu_ja_pkg::quat_t                     quat_b_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output imu_ja_pkg::angle_t                    joint_angle,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imu_ja_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [imu_ja_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import imu_ja_pkg::*;

  logic angle_method;
  logic anatomical_supplement;
  logic en;
  logic [NUM_STAGES-1:0] vld;

  assign en        = !vld[NUM_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NUM_STAGES-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_method          <= 1'b0;
      anatomical_supplement <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ANGLE_METHOD: angle_method          <= cfg_data[0];
        CFG_SUPPLEMENT:   anatomical_supplement <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // P1: raw products
  qprod_t p1_a, p1_b;
  logic signed [31:0] p1_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a.ww <= quat_a_w * quat_a_w;
      p1_a.xx <= quat_a_x * quat_a_x;
      p1_a.yy <= quat_a_y * quat_a_y;
      p1_a.zz <= quat_a_z * quat_a_z;
      p1_a.xy <= quat_a_x * quat_a_y;
      p1_a.wz <= quat_a_w * quat_a_z;
      p1_a.yz <= quat_a_y * quat_a_z;
      p1_a.wx <= quat_a_w * quat_a_x;
      p1_b.ww <= quat_b_w * quat_b_w;
      p1_b.xx <= quat_b_x * quat_b_x;
      p1_b.yy <= quat_b_y * quat_b_y;
      p1_b.zz <= quat_b_z * quat_b_z;
      p1_b.xy <= quat_b_x * quat_b_y;
      p1_b.wz <= quat_b_w * quat_b_z;
      p1_b.yz <= quat_b_y * quat_b_z;
      p1_b.wx <= quat_b_w * quat_b_x;
      p1_r[0] <= quat_a_w * quat_b_w;
      p1_r[1] <= quat_a_x * quat_b_x;
      p1_r[2] <= quat_a_y * quat_b_y;
      p1_r[3] <= quat_a_z * quat_b_z;
    end
  end

  // P2: squared norms, rotated +Y vectors, real part of qB * conj(qA)
  feat_t p2_ft, p2_next;
  logic signed [33:0] ca [3];
  logic signed [33:0] cb [3];
  logic signed [33:0] rr;

  always_comb begin
    ca[0] = (34'(p1_a.xy) - 34'(p1_a.wz)) <<< 1;
    ca[1] = 34'(p1_a.ww) - 34'(p1_a.xx) + 34'(p1_a.yy) - 34'(p1_a.zz);
    ca[2] = (34'(p1_a.yz) + 34'(p1_a.wx)) <<< 1;
    cb[0] = (34'(p1_b.xy) - 34'(p1_b.wz)) <<< 1;
    cb[1] = 34'(p1_b.ww) - 34'(p1_b.xx) + 34'(p1_b.yy) - 34'(p1_b.zz);
    cb[2] = (34'(p1_b.yz) + 34'(p1_b.wx)) <<< 1;
    rr = 34'(p1_r[0]) + 34'(p1_r[1]) + 34'(p1_r[2]) + 34'(p1_r[3]);
    p2_next.m_a = 33'(p1_a.ww) + 33'(p1_a.xx) + 33'(p1_a.yy) + 33'(p1_a.zz);
    p2_next.m_b = 33'(p1_b.ww) + 33'(p1_b.xx) + 33'(p1_b.yy) + 33'(p1_b.zz);
    for (int i = 0; i < 3; i++) begin
      p2_next.ca_mag[i] = mag34(ca[i]);
      p2_next.ca_neg[i] = ca[i][33];
      p2_next.cb_mag[i] = mag34(cb[i]);
      p2_next.cb_neg[i] = cb[i][33];
    end
    p2_next.r_mag = mag34(rr);
    p2_next.r_neg = rr[33];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ft <= p2_next;
    end
  end

  // square root of |q|^2 * 2^30, one result digit per stage
  sqrt_t sq    [SQ_STEPS];
  feat_t sq_ft [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'd1 << (62 - 2 * k);
    sqrt_t cur, nxt;
    feat_t cur_ft;
    logic [62:0] ta, tb;

    if (k == 0) begin : g_src
      assign cur    = '{va: {p2_ft.m_a, 30'd0}, ra: '0, vb: {p2_ft.m_b, 30'd0}, rb: '0};
      assign cur_ft = p2_ft;
    end else begin : g_chain
      assign cur    = sq[k-1];
      assign cur_ft = sq_ft[k-1];
    end

    always_comb begin
      ta = cur.ra + BIT;
      tb = cur.rb + BIT;
      if (cur.va >= ta) begin
        nxt.va = cur.va - ta;
        nxt.ra = (cur.ra >> 1) + BIT;
      end else begin
        nxt.va = cur.va;
        nxt.ra = cur.ra >> 1;
      end
      if (cur.vb >= tb) begin
        nxt.vb = cur.vb - tb;
        nxt.rb = (cur.rb >> 1) + BIT;
      end else begin
        nxt.vb = cur.vb;
        nxt.rb = cur.rb >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k]    <= nxt;
        sq_ft[k] <= cur_ft;
      end
    end
  end

  // product of the two norms, back to Q28
  logic [32:0] pd;
  feat_t       mul_ft;
  logic [63:0] norm_prod;

  assign norm_prod = 64'(sq[SQ_STEPS-1].ra[31:0]) * 64'(sq[SQ_STEPS-1].rb[31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      pd     <= norm_prod[62:30];
      mul_ft <= sq_ft[SQ_STEPS-1];
    end
  end

  // divider operands; degenerate cases become 0/1 (zero) or pd/pd (one)
  lane_t prep [LANES];
  lane_t prep_next [LANES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prep_next[i].quo   = '0;
      prep_next[i+3].quo = '0;
      prep_next[i].neg   = mul_ft.ca_neg[i];
      prep_next[i+3].neg = mul_ft.cb_neg[i];
      if (mul_ft.m_a <= NEAR_ZERO_THR) begin
        prep_next[i].rem = '0;
        prep_next[i].den = 33'd1;
      end else begin
        prep_next[i].rem = {1'b0, mul_ft.ca_mag[i]};
        prep_next[i].den = mul_ft.m_a;
      end
      if (mul_ft.m_b <= NEAR_ZERO_THR) begin
        prep_next[i+3].rem = '0;
        prep_next[i+3].den = 33'd1;
      end else begin
        prep_next[i+3].rem = {1'b0, mul_ft.cb_mag[i]};
        prep_next[i+3].den = mul_ft.m_b;
      end
    end
    if (angle_method) begin
      prep_next[0].neg = mul_ft.r_neg;
      if (pd == '0) begin
        prep_next[0].rem = '0;
        prep_next[0].den = 33'd1;
      end else if (mul_ft.r_mag > pd) begin
        // ratio above one clamps to exactly one
        prep_next[0].rem = {1'b0, pd};
        prep_next[0].den = pd;
      end else begin
        prep_next[0].rem = {1'b0, mul_ft.r_mag};
        prep_next[0].den = pd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

  // restoring divide, quotient <= 2^30, one bit per stage
  lane_t dv [DIV_STEPS][LANES];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    lane_t cur [LANES];
    lane_t nxt [LANES];

    if (k == 0) begin : g_src
      assign cur = prep;
    end else begin : g_chain
      assign cur = dv[k-1];
    end

    always_comb begin
      logic [33:0] t;
      logic        ge;
      for (int j = 0; j < LANES; j++) begin
        t  = (k == 0) ? cur[j].rem : {cur[j].rem[32:0], 1'b0};
        ge = t >= {1'b0, cur[j].den};
        nxt[j].rem = ge ? t - {1'b0, cur[j].den} : t;
        nxt[j].den = cur[j].den;
        nxt[j].quo = {cur[j].quo[29:0], ge};
        nxt[j].neg = cur[j].neg;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= nxt;
      end
    end
  end

  // dot product of the unit vectors
  logic [61:0] d1_prod [3];
  logic [2:0]  d1_neg;
  logic [30:0] d1_q0;
  logic        d1_neg0;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_prod[i] <= 62'(dv[DIV_STEPS-1][i].quo) * 62'(dv[DIV_STEPS-1][i+3].quo);
        d1_neg[i]  <= dv[DIV_STEPS-1][i].neg ^ dv[DIV_STEPS-1][i+3].neg;
      end
      d1_q0   <= dv[DIV_STEPS-1][0].quo;
      d1_neg0 <= dv[DIV_STEPS-1][0].neg;
    end
  end

  logic signed [62:0] d2_dot;
  logic signed [62:0] d2_dot_next;
  logic [30:0]        d2_q0;
  logic               d2_neg0;

  always_comb begin
    logic signed [62:0] term;
    d2_dot_next = '0;
    for (int i = 0; i < 3; i++) begin
      term = $signed({1'b0, d1_prod[i]});
      d2_dot_next = d1_neg[i] ? d2_dot_next - term : d2_dot_next + term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_dot  <= d2_dot_next;
      d2_q0   <= d1_q0;
      d2_neg0 <= d1_neg0;
    end
  end

  // round to Q30, clamp, pick the cosine of the active method
  logic signed [31:0] d3_cos;
  logic signed [31:0] d3_cos_next;
  logic [62:0]        dot_abs;
  logic [32:0]        dot_q30;
  logic [31:0]        cos_mag;
  logic               cos_neg;

  always_comb begin
    dot_abs = d2_dot[62] ? 63'(-d2_dot) : 63'(d2_dot);
    dot_q30 = 33'((dot_abs + 63'(ONE_Q30 >> 1)) >> 30);
    if (angle_method) begin
      cos_mag = 32'(d2_q0);
      cos_neg = d2_neg0;
    end else begin
      cos_mag = (dot_q30 > 33'(ONE_Q30)) ? ONE_Q30 : dot_q30[31:0];
      cos_neg = d2_dot[62];
    end
    d3_cos_next = cos_neg ? -$signed(cos_mag) : $signed(cos_mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_cos <= d3_cos_next;
    end
  end

  // arc cosine by angle doubling, one digit per stage
  logic signed [31:0] ac_c [ACOS_STEPS];
  logic [31:0]        ac_t [ACOS_STEPS];

  for (genvar k = 0; k < ACOS_STEPS; k++) begin : g_acos
    logic signed [31:0] c_in, c_nxt;
    logic [31:0]        t_in;
    logic               hi;
    logic [30:0]        m;
    logic [61:0]        msq;
    logic [61:0]        msq_r;
    logic [31:0]        s;
    logic signed [31:0] c_neg;

    if (k == 0) begin : g_src
      assign c_in = d3_cos;
      assign t_in = '0;
    end else begin : g_chain
      assign c_in = ac_c[k-1];
      assign t_in = ac_t[k-1];
    end

    always_comb begin
      hi    = c_in[31];
      c_neg = -c_in;
      m     = hi ? c_neg[30:0] : c_in[30:0];
      msq   = 62'(m) * 62'(m);
      msq_r = msq + 62'(ONE_Q30 >> 2);
      s     = msq_r[60:29];
      c_nxt = hi ? $signed(ONE_Q30 - s) : $signed(s - ONE_Q30);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ac_c[k] <= c_nxt;
        ac_t[k] <= {t_in[30:0], hi};
      end
    end
  end

  // scale digits to degrees, then supplement and saturate
  logic [15:0] f1_ang;
  logic [55:0] ang_prod;

  assign ang_prod = 56'(ac_t[ACOS_STEPS-1]) * 56'(angle_method ? SPAN_DIFF : SPAN_BONE)
                    + 56'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ang <= ang_prod[47:32];
    end
  end

  logic signed [17:0] ang_s;

  always_comb begin
    if (anatomical_supplement) begin
      ang_s = $signed(18'(ANGLE_FULL)) - $signed(18'(f1_ang));
    end else begin
      ang_s = $signed(18'(f1_ang));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ang_s < 0) begin
        joint_angle <= '0;
      end else if (ang_s > $signed(18'(ANGLE_FULL))) begin
        joint_angle <= ANGLE_FULL;
      end else begin
        joint_angle <= ang_s[ANGLE_W-1:0];
      end
    end
  end

endmodule
